// ===== rtl/i4dq_pkg.sv =====
`default_nettype none
package i4dq_pkg;

  localparam logic [31:0] QnanCanon = 32'h7fc0_0000;
  localparam logic [30:0] InfMag    = 31'h7f80_0000;

  // configuration register indexes
  typedef enum logic [0:0] {
    RegGroupsPerRow = 1'b0,
    RegRowCount     = 1'b1
  } cfg_reg_e;

  // lane product, registered between the lane and the merge stage
  typedef struct packed {
    logic        sign;
    logic        special;   // result fully formed in word
    logic [31:0] word;
    logic [11:0] prod;      // significand times magnitude, 8x4 bits
    logic [7:0]  ex;        // effective exponent (1 for subnormal)
  } lane_prod_t;

  // count leading zeros of a 12-bit value
  function automatic logic [3:0] clz12(input logic [11:0] v);
    logic [3:0] n;
    logic       hit;
    n   = 4'd12;
    hit = 1'b0;
    for (int i = 11; i >= 0; i--) begin
      if (v[i] && !hit) begin
        n   = 4'(11 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/int4_group_dequantizer.sv =====
// int4_group_dequantizer: one packed weight byte in, two fp32 products out
// an input byte passes the lane register, then the output register, before the output request
// throughput: one byte per cycle while the output is not stalled, two nibble lanes in parallel, merge per lane
// reset: rst_ni async low clears valids and counters, configuration registers reset to 1
// input stays ready while a result waits only if the lane stage is empty
`default_nettype none
module int4_group_dequantizer #(
  parameter int unsigned GROUP_COLUMNS = 32,
  parameter int unsigned MAX_GROUPS    = 512
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // packed_byte[7:0], scale_bits[23:8]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // even_value[31:0], odd_value[63:32]
  output logic             m_axis_tlast,   // row_end
  output logic [0:0]       m_axis_tuser    // matrix_end
);
  import i4dq_pkg::*;

  localparam int unsigned HalfCols = (GROUP_COLUMNS / 2 == 0) ? 1 : GROUP_COLUMNS / 2;
  localparam int unsigned MaxBytes = HalfCols * MAX_GROUPS;
  localparam int unsigned PosW     = $clog2(MaxBytes + 1);
  localparam int unsigned GW       = 10;

  logic [GW-1:0] groups_q;
  logic [15:0]   rows_q;
  logic [PosW-1:0] bpos_q;
  logic [15:0]   rpos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      groups_q <= GW'(1);
      rows_q   <= 16'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegGroupsPerRow: groups_q <= cfg_data_i[GW-1:0];
        RegRowCount:     rows_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped geometry; bytes per row is a multiply by a constant
  logic [PosW+GW-1:0] g_eff;
  logic [PosW+GW-1:0] last_byte;
  logic [15:0]        last_row;
  always_comb begin
    g_eff = (groups_q == '0) ? (PosW+GW)'(1) : (PosW+GW)'(groups_q);
    if (g_eff > (PosW+GW)'(MAX_GROUPS)) g_eff = (PosW+GW)'(MAX_GROUPS);
    last_byte = (PosW+GW)'(g_eff * (PosW+GW)'(HalfCols)) - (PosW+GW)'(1);
    last_row  = (rows_q == 16'd0) ? 16'd0 : rows_q - 16'd1;
  end

  // pipeline control: stage 1 (lane regs), stage 2 (output regs)
  logic       s1_valid_q, s2_valid_q;
  logic       s1_adv, s2_load;
  assign s2_load       = s1_valid_q && (!s2_valid_q || m_axis_tready);
  assign s1_adv        = !s1_valid_q || s2_load;
  assign s_axis_tready = s1_adv;

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // position counters update on accept
  logic rend, mend;
  always_comb begin
    rend = (PosW+GW)'(bpos_q) >= last_byte;
    mend = rend && (rpos_q >= last_row);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpos_q <= '0;
      rpos_q <= '0;
    end else if (in_acc) begin
      if (rend) begin
        bpos_q <= '0;
        rpos_q <= mend ? 16'd0 : rpos_q + 16'd1;
      end else begin
        bpos_q <= bpos_q + PosW'(1);
      end
    end
  end

  // lanes
  lane_prod_t lane_d [2];
  lane_prod_t lane_q [2];
  logic       rend_q, mend_q;

  i4dq_lane u_lane_even (
    .nibble_i(s_axis_tdata[3:0]), .scale_i(s_axis_tdata[23:8]), .prod_o(lane_d[0])
  );
  i4dq_lane u_lane_odd (
    .nibble_i(s_axis_tdata[7:4]), .scale_i(s_axis_tdata[23:8]), .prod_o(lane_d[1])
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      lane_q[0] <= lane_d[0];
      lane_q[1] <= lane_d[1];
      rend_q    <= rend;
      mend_q    <= mend;
    end
  end

  // merge: normalize each lane and pack the result
  logic [31:0] even_v, odd_v;
  i4dq_norm u_norm_even (.p_i(lane_q[0]), .value_o(even_v));
  i4dq_norm u_norm_odd  (.p_i(lane_q[1]), .value_o(odd_v));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_load) begin
      s2_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      m_axis_tdata <= {odd_v, even_v};
      m_axis_tlast <= rend_q;
      m_axis_tuser <= mend_q;
    end
  end

  assign m_axis_tvalid = s2_valid_q;

  // matrix end always marks a row end
  a_mend_rend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast) else $error("matrix end without row end");
  // a stalled output keeps its valid
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("output dropped");
  // byte position returns to zero after the last byte of a row
  a_bpos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && rend |=> bpos_q == '0) else $error("byte position not cleared");
endmodule
`default_nettype wire

// ===== rtl/i4dq_lane.sv =====
`default_nettype none
module i4dq_lane (
  input  wire logic [3:0]          nibble_i,
  input  wire logic [15:0]         scale_i,
  output i4dq_pkg::lane_prod_t     prod_o
);
  import i4dq_pkg::*;

  logic       qneg;
  logic [3:0] mag;
  logic [7:0] ex;
  logic [6:0] fr;
  logic [7:0] sig;

  always_comb begin
    qneg = nibble_i[3];
    mag  = qneg ? (4'd0 - nibble_i) : nibble_i;
    ex   = scale_i[14:7];
    fr   = scale_i[6:0];
    sig  = (ex != 8'd0) ? {1'b1, fr} : {1'b0, fr};
    prod_o.sign    = scale_i[15] ^ qneg;
    prod_o.ex      = (ex != 8'd0) ? ex : 8'd1;
    prod_o.prod    = 12'(sig) * 12'(mag);
    prod_o.special = 1'b0;
    prod_o.word    = '0;
    if (ex == 8'hff) begin
      prod_o.special = 1'b1;
      if (fr != 7'd0)         prod_o.word = {scale_i, 16'h0} | 32'h0040_0000;
      else if (mag == 4'd0)   prod_o.word = QnanCanon;
      else                    prod_o.word = {prod_o.sign, InfMag};
    end else if (mag == 4'd0 || (ex == 8'd0 && fr == 7'd0)) begin
      prod_o.special = 1'b1;
      prod_o.word    = {prod_o.sign, 31'd0};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/i4dq_norm.sv =====
`default_nettype none
module i4dq_norm (
  input  wire i4dq_pkg::lane_prod_t p_i,
  output logic [31:0]               value_o
);
  import i4dq_pkg::*;

  // product value = prod * 2^(ex-127-7-16+16) with binary point at bit 7
  logic [3:0]  lz;
  logic [9:0]  e_norm;   // biased exponent when msb placed at bit 23
  logic [11:0] sh;
  logic [22:0] frac;
  logic [4:0]  rsh;

  always_comb begin
    lz     = clz12(p_i.prod);
    // msb at bit (11-lz); fp exponent = ex + (11-lz) - 7
    e_norm = 10'(p_i.ex) + 10'd4 - 10'(lz);
    sh     = p_i.prod << lz;
    frac   = {sh[10:0], 12'd0};
    rsh    = '0;
    if (p_i.special) begin
      value_o = p_i.word;
    end else if (e_norm[9] || e_norm == 10'd0) begin
      // stays subnormal: fraction = prod << (16 + ex - 1), ex is 1 here
      value_o = {p_i.sign, 8'd0, 23'({p_i.prod, 16'd0} >> rsh)};
    end else if (e_norm >= 10'd255) begin
      value_o = {p_i.sign, InfMag};
    end else begin
      value_o = {p_i.sign, e_norm[7:0], frac};
    end
  end
endmodule
`default_nettype wire
